FILE: rtl/swmm_pkg.sv
// swmm_pkg: shared constants, types and helpers for the sliding window min/max block
// no dependencies; imported by sliding_window_min_max and its checker
package swmm_pkg;

   localparam int WINDOW     = 6;
   localparam int PRICE_BITS = 24;
   localparam int SEQ_W      = 16;
   localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int SUM_W      = CNT_W + 1;

   typedef logic [PRICE_BITS-1:0] price_type;
   typedef logic [SEQ_W-1:0]      seq_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   // ring position head + k, k never above WINDOW
   function automatic pos_type wrap_pos(input pos_type head, input cnt_type k);
      logic [SUM_W-1:0] s;
      s = SUM_W'(head) + SUM_W'(k);
      if (s >= SUM_W'(WINDOW)) begin
         s = s - SUM_W'(WINDOW);
      end
      return s[POS_W-1:0];
   endfunction

endpackage

FILE: rtl/sliding_window_min_max.sv
// sliding_window_min_max: windowed max of bar highs and min of bar lows
// depends on swmm_pkg
//
// usage
//  - req channel: one word per price bar, req_bar_high and req_bar_low, unsigned
//    prices in hundredths; valid/ready handshake
//  - rsp channel: one word per bar, rsp_window_high (max high) and rsp_window_low
//    (min low) over the last WINDOW bars, the current bar included
//  - two monotonic deques (high, low) live in small register rings; a single
//    comparator walks them under a small sequencer, one entry per cycle
//  - per bar: an accept, then for each deque the expired front entries one by
//    one plus a check, the popped back entries one by one plus a check, a push
//    and a front read, then a handover; the first bar after reset finds both
//    deques empty and skips the checks
//  - req_ready is high only while the sequencer is idle; the result register
//    separates the two sides, so the next bar is taken while a result waits
//  - a stalled receiver holds the result; a finished bar waits in the done
//    state until the result register is free
//  - reset (synchronous, active high) empties both deques, clears the bar
//    sequence and drops any pending result word
module sliding_window_min_max (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  swmm_pkg::price_type req_bar_high,
   input  swmm_pkg::price_type req_bar_low,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output swmm_pkg::price_type rsp_window_high,
   output swmm_pkg::price_type rsp_window_low
);
   import swmm_pkg::*;

   // sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPIRE = 3'd1;
   localparam logic [2:0] ST_POP    = 3'd2;
   localparam logic [2:0] ST_PUSH   = 3'd3;
   localparam logic [2:0] ST_FRONT  = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   // deque select: 0 keeps maxima of highs, 1 keeps minima of lows
   localparam logic DQ_HIGH = 1'b0;
   localparam logic DQ_LOW  = 1'b1;

   logic [2:0] state_ff, state_in;
   logic       sel_ff, sel_in;
   pos_type    head_ff [2];
   pos_type    head_in [2];
   cnt_type    count_ff [2];
   cnt_type    count_in [2];
   seq_type    seq_ff, seq_in;

   // latched bar
   price_type  bar_high_ff, bar_low_ff;

   // deque storage, one ring per deque
   price_type  val_mem [2][WINDOW];
   seq_type    idx_mem [2][WINDOW];

   // front values of the current bar
   price_type  front_ff [2];

   logic       rsp_valid_ff, rsp_valid_in;
   price_type  rsp_high_ff, rsp_low_ff;

   // datapath
   pos_type    cur_head;
   cnt_type    cur_cnt;
   pos_type    rd_pos;
   pos_type    wr_pos;
   logic       wr_en;
   logic       full;
   price_type  rd_val;
   seq_type    rd_idx;
   seq_type    age;
   price_type  new_val;
   price_type  cmp_a, cmp_b;
   logic       cmp_lt;
   logic       front_load;
   logic       rsp_load;

   assign cur_head = head_ff[sel_ff];
   assign cur_cnt  = count_ff[sel_ff];
   assign new_val  = (sel_ff == DQ_LOW) ? bar_low_ff : bar_high_ff;
   assign full     = (cur_cnt == CNT_W'(WINDOW));

   // one read address per cycle: front for expiry and result, back for pops
   always_comb begin
      case (state_ff)
         ST_POP:  rd_pos = wrap_pos(cur_head, cur_cnt - CNT_W'(1));
         default: rd_pos = cur_head;
      endcase
   end

   assign rd_val = val_mem[sel_ff][rd_pos];
   assign rd_idx = idx_mem[sel_ff][rd_pos];
   assign age    = seq_ff - rd_idx;

   // full ring cannot happen after expiry; then the oldest slot is overwritten
   assign wr_pos = full ? cur_head : wrap_pos(cur_head, cur_cnt);
   assign wr_en  = (state_ff == ST_PUSH);

   // the shared comparator: age check during expiry, dominance during pops
   always_comb begin
      case (state_ff)
         ST_EXPIRE: begin
            cmp_a = PRICE_BITS'(age);
            cmp_b = PRICE_BITS'(WINDOW);
         end
         ST_POP: begin
            if (sel_ff == DQ_HIGH) begin
               cmp_a = rd_val;
               cmp_b = new_val;
            end else begin
               cmp_a = new_val;
               cmp_b = rd_val;
            end
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end

   assign cmp_lt = (cmp_a < cmp_b);

   assign req_ready  = (state_ff == ST_IDLE);
   assign front_load = (state_ff == ST_FRONT);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      sel_in      = sel_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      seq_in      = seq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sel_in   = DQ_HIGH;
               state_in = ST_EXPIRE;
            end
         end
         ST_EXPIRE: begin
            // drop a front entry WINDOW or more bars old
            if (cur_cnt == '0) begin
               state_in = ST_PUSH;
            end else if (!cmp_lt) begin
               head_in[sel_ff]  = wrap_pos(cur_head, CNT_W'(1));
               count_in[sel_ff] = cur_cnt - CNT_W'(1);
            end else begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            // strictly dominated back entries go; equal values stay
            if (cur_cnt == '0) begin
               state_in = ST_PUSH;
            end else if (cmp_lt) begin
               count_in[sel_ff] = cur_cnt - CNT_W'(1);
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (full) begin
               head_in[sel_ff] = wrap_pos(cur_head, CNT_W'(1));
            end else begin
               count_in[sel_ff] = cur_cnt + CNT_W'(1);
            end
            state_in = ST_FRONT;
         end
         ST_FRONT: begin
            if (sel_ff == DQ_HIGH) begin
               sel_in   = DQ_LOW;
               state_in = ST_EXPIRE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               seq_in   = seq_ff + SEQ_W'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register: load on handover, clear when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= DQ_HIGH;
         head_ff      <= '{default: '0};
         count_ff     <= '{default: '0};
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         bar_high_ff <= req_bar_high;
         bar_low_ff  <= req_bar_low;
      end
      if (front_load) begin
         front_ff[sel_ff] <= rd_val;
      end
      if (rsp_load) begin
         rsp_high_ff <= front_ff[DQ_HIGH];
         rsp_low_ff  <= front_ff[DQ_LOW];
      end
   end

   // deque rings
   always_ff @(posedge clock) begin
      if (wr_en) begin
         val_mem[sel_ff][wr_pos] <= new_val;
         idx_mem[sel_ff][wr_pos] <= seq_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_high = rsp_high_ff;
   assign rsp_window_low  = rsp_low_ff;

endmodule

FILE: rtl/swmm_checker.sv
// swmm_checker: port-level checks for sliding_window_min_max, bound to the top level
// depends on swmm_pkg
module swmm_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input swmm_pkg::price_type rsp_window_high,
   input swmm_pkg::price_type rsp_window_low
);
   import swmm_pkg::*;

   // words accepted but not yet delivered
   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_high)
         && $stable(rsp_window_low))
      else $error("result word changed while stalled");

   // busy after taking a bar
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("input taken again right after accept");

   // reset drops any pending result
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // no result without a bar behind it
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result word without an accepted bar");

   // at most one bar in work plus one result waiting
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3 && (pend_ff != 2'd2 || !req_ready))
      else $error("too many bars outstanding");

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (.*);
